FILE: hdl/assert_macros.svh
// Assertion macros of the mode controller, used by its state machine.
// No dependencies; each macro expects clk in scope, EMC_ASSERT also rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define EMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define EMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/emc_pkg.sv
// Types and constants of the event mode controller.
// No dependencies; used by the stages, the state machine, the top and the testbench.
package emc_pkg;

  typedef enum logic [3:0] {
    MODE_BOOT   = 4'd0,
    MODE_IDLE   = 4'd1,
    MODE_ATTN   = 4'd2,
    MODE_RESP   = 4'd3,
    MODE_TOUCH  = 4'd4,
    MODE_SLEEP  = 4'd5,
    MODE_ERROR  = 4'd6,
    MODE_SAFE   = 4'd7,
    MODE_MED    = 4'd8,
    MODE_SILENT = 4'd9
  } mode_t;

  localparam logic [3:0] CMD_INIT        = 4'd0;
  localparam logic [3:0] CMD_TICK        = 4'd1;
  localparam logic [3:0] CMD_BOOT_DONE   = 4'd2;
  localparam logic [3:0] CMD_TAP         = 4'd3;
  localparam logic [3:0] CMD_LONG_PRESS  = 4'd4;
  localparam logic [3:0] CMD_TOUCH_WAKE  = 4'd5;
  localparam logic [3:0] CMD_VOICE_START = 4'd6;
  localparam logic [3:0] CMD_VOICE_END   = 4'd7;
  localparam logic [3:0] CMD_AUDIO_START = 4'd8;
  localparam logic [3:0] CMD_AUDIO_END   = 4'd9;
  localparam logic [3:0] CMD_FAULT       = 4'd10;
  localparam logic [3:0] CMD_MED_IN      = 4'd11;
  localparam logic [3:0] CMD_MED_OUT     = 4'd12;
  localparam logic [3:0] CMD_SILENT_IN   = 4'd13;
  localparam logic [3:0] CMD_SILENT_OUT  = 4'd14;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  localparam int unsigned IDLE_MS_W = 26;
  localparam int unsigned TIMER_W   = 17;

  localparam logic [9:0]           MS_PER_S       = 10'd1000;
  localparam logic [IDLE_MS_W-1:0] IDLE_LIMIT_RST = 26'd120000;
  localparam logic [TIMER_W-1:0]   TOUCH_LIMIT_MS = 17'd2000;
  localparam logic [TIMER_W-1:0]   ATTN_LIMIT_MS  = 17'd8000;

  typedef struct packed {
    logic [3:0]  command;
    logic [15:0] elapsed_ms;
    logic        listening;
    logic        start_safe;
  } item_t;

  typedef struct packed {
    logic [3:0] mode_now;
    logic [3:0] mode_before;
    logic       changed;
    logic [1:0] status;
  } result_t;

endpackage

FILE: hdl/emc_if.sv
// Valid/ready channel interfaces of the mode controller.
// Depends on nothing; event words in, result words out.
interface emc_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic [15:0] elapsed_ms;
  logic        listening;
  logic        start_safe;

  modport source (output valid, command, elapsed_ms, listening, start_safe, input ready);
  modport sink   (input valid, command, elapsed_ms, listening, start_safe, output ready);
endinterface

interface emc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] mode_now;
  logic [3:0] mode_before;
  logic       changed;
  logic [1:0] status;

  modport source (output valid, mode_now, mode_before, changed, status, input ready);
  modport sink   (input valid, mode_now, mode_before, changed, status, output ready);
endinterface

FILE: hdl/emc_in_stage.sv
// Input register of the mode controller: holds one event word.
// Depends on emc_pkg and emc_in_if.
module emc_in_stage (
  input  logic           clk,
  input  logic           rst,
  emc_in_if.sink         in_ch,
  input  logic           adv,
  output logic           vld,
  output emc_pkg::item_t item
);

  logic take;

  // Free slot, or the held word moves on this cycle.
  assign in_ch.ready = !vld || adv;
  assign take        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (take) begin
      vld <= 1'b1;
    end else if (adv) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.command    <= in_ch.command;
      item.elapsed_ms <= in_ch.elapsed_ms;
      item.listening  <= in_ch.listening;
      item.start_safe <= in_ch.start_safe;
    end
  end

endmodule

FILE: hdl/emc_fsm.sv
// Mode state machine with the three millisecond timers and the timeout register.
// Depends on emc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module emc_fsm (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data,
  input  logic             fire,
  input  emc_pkg::item_t   item,
  output emc_pkg::result_t res
);

  // Timeout kept already scaled to ms.
  logic [emc_pkg::IDLE_MS_W-1:0] limit_ms;

  emc_pkg::mode_t mode, mode_next;
  logic           started, started_next;
  logic [emc_pkg::IDLE_MS_W-1:0] idle_ms, idle_ms_next, idle_sum;
  logic [emc_pkg::TIMER_W-1:0]   touch_ms, touch_ms_next, touch_sum;
  logic [emc_pkg::TIMER_W-1:0]   attn_ms, attn_ms_next, attn_sum;
  logic [1:0]     status;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_ms <= emc_pkg::IDLE_LIMIT_RST;
    end else if (cfg_wr_en) begin
      limit_ms <= {10'd0, cfg_wr_data} * {16'd0, emc_pkg::MS_PER_S};
    end
  end

  assign idle_sum  = idle_ms + {10'd0, item.elapsed_ms};
  assign touch_sum = touch_ms + {1'b0, item.elapsed_ms};
  assign attn_sum  = attn_ms + {1'b0, item.elapsed_ms};

  always_comb begin
    mode_next     = mode;
    started_next  = started;
    idle_ms_next  = idle_ms;
    touch_ms_next = touch_ms;
    attn_ms_next  = attn_ms;
    status        = emc_pkg::ST_OK;

    if (item.command == emc_pkg::CMD_INIT) begin
      if (started) begin
        status = emc_pkg::ST_REFUSED;
      end else begin
        mode_next     = item.start_safe ? emc_pkg::MODE_SAFE : emc_pkg::MODE_BOOT;
        idle_ms_next  = '0;
        touch_ms_next = '0;
        started_next  = 1'b1;
      end
    end else if (!started) begin
      status = emc_pkg::ST_IGNORED;
    end else begin
      case (item.command)
        emc_pkg::CMD_TICK: begin
          // Only the timer of the current mode runs; the others clear.
          idle_ms_next  = '0;
          touch_ms_next = '0;
          attn_ms_next  = '0;
          if (mode == emc_pkg::MODE_IDLE) begin
            if (idle_sum >= limit_ms) begin
              mode_next = emc_pkg::MODE_SLEEP;
            end else begin
              idle_ms_next = idle_sum;
            end
          end
          if (mode == emc_pkg::MODE_TOUCH) begin
            if (touch_sum >= emc_pkg::TOUCH_LIMIT_MS) begin
              mode_next = emc_pkg::MODE_IDLE;
            end else begin
              touch_ms_next = touch_sum;
            end
          end
          if (mode == emc_pkg::MODE_ATTN && !item.listening) begin
            if (attn_sum >= emc_pkg::ATTN_LIMIT_MS) begin
              mode_next = emc_pkg::MODE_IDLE;
            end else begin
              attn_ms_next = attn_sum;
            end
          end
        end
        emc_pkg::CMD_BOOT_DONE: begin
          if (mode == emc_pkg::MODE_BOOT) mode_next = emc_pkg::MODE_IDLE;
        end
        emc_pkg::CMD_TAP: begin
          if (mode == emc_pkg::MODE_IDLE) begin
            mode_next = emc_pkg::MODE_ATTN;
          end else if (mode == emc_pkg::MODE_ATTN || mode == emc_pkg::MODE_RESP) begin
            touch_ms_next = '0;
            mode_next     = emc_pkg::MODE_TOUCH;
          end else if (mode == emc_pkg::MODE_SLEEP || mode == emc_pkg::MODE_MED ||
                       mode == emc_pkg::MODE_SILENT) begin
            mode_next = emc_pkg::MODE_IDLE;
          end
        end
        emc_pkg::CMD_LONG_PRESS: begin
          if (mode == emc_pkg::MODE_IDLE || mode == emc_pkg::MODE_ATTN ||
              mode == emc_pkg::MODE_SLEEP) begin
            touch_ms_next = '0;
            mode_next     = emc_pkg::MODE_TOUCH;
          end else if (mode == emc_pkg::MODE_MED || mode == emc_pkg::MODE_SILENT) begin
            mode_next = emc_pkg::MODE_IDLE;
          end
        end
        emc_pkg::CMD_TOUCH_WAKE: begin
          if (mode == emc_pkg::MODE_SLEEP) mode_next = emc_pkg::MODE_IDLE;
        end
        emc_pkg::CMD_VOICE_END: begin
          if (mode == emc_pkg::MODE_ATTN) mode_next = emc_pkg::MODE_IDLE;
        end
        emc_pkg::CMD_AUDIO_START: begin
          if (mode == emc_pkg::MODE_IDLE || mode == emc_pkg::MODE_ATTN ||
              mode == emc_pkg::MODE_TOUCH) begin
            mode_next = emc_pkg::MODE_RESP;
          end
        end
        emc_pkg::CMD_AUDIO_END: begin
          if (mode == emc_pkg::MODE_RESP) mode_next = emc_pkg::MODE_IDLE;
        end
        emc_pkg::CMD_FAULT: begin
          mode_next = emc_pkg::MODE_ERROR;
        end
        emc_pkg::CMD_MED_IN: begin
          if (mode == emc_pkg::MODE_IDLE) mode_next = emc_pkg::MODE_MED;
        end
        emc_pkg::CMD_MED_OUT: begin
          if (mode == emc_pkg::MODE_MED) mode_next = emc_pkg::MODE_IDLE;
        end
        emc_pkg::CMD_SILENT_IN: begin
          if (mode == emc_pkg::MODE_IDLE) mode_next = emc_pkg::MODE_SILENT;
        end
        emc_pkg::CMD_SILENT_OUT: begin
          if (mode == emc_pkg::MODE_SILENT) mode_next = emc_pkg::MODE_IDLE;
        end
        default: begin
          // voice start and the unused code: accepted, no effect
        end
      endcase
    end
  end

  assign res.mode_now    = mode_next;
  assign res.mode_before = mode;
  assign res.changed     = (mode_next != mode);
  assign res.status      = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= emc_pkg::MODE_BOOT;
      started  <= 1'b0;
      idle_ms  <= '0;
      touch_ms <= '0;
      attn_ms  <= '0;
    end else if (fire) begin
      mode     <= mode_next;
      started  <= started_next;
      idle_ms  <= idle_ms_next;
      touch_ms <= touch_ms_next;
      attn_ms  <= attn_ms_next;
    end
  end

  `EMC_ASSERT(a_started_sticky, started |=> started, "started flag dropped")
  `EMC_ASSERT(a_boot_before_init, !started |-> mode == emc_pkg::MODE_BOOT,
              "mode left boot before init")
  `EMC_ASSERT(a_error_no_exit, mode == emc_pkg::MODE_ERROR |=> mode == emc_pkg::MODE_ERROR,
              "error mode was left")
  `EMC_ASSERT(a_safe_exit_fault,
              (mode == emc_pkg::MODE_SAFE && !(fire && item.command == emc_pkg::CMD_FAULT))
              |=> mode == emc_pkg::MODE_SAFE, "safe mode left without fault")

endmodule

FILE: hdl/emc_out_stage.sv
// Result register of the mode controller: holds one result word for the sink.
// Depends on emc_pkg and emc_out_if.
module emc_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  emc_pkg::result_t res,
  output logic             can_load,
  emc_out_if.source        out_ch
);

  logic             vld;
  emc_pkg::result_t data;

  assign can_load = !vld || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= 1'b1;
    end else if (out_ch.ready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign out_ch.valid       = vld;
  assign out_ch.mode_now    = data.mode_now;
  assign out_ch.mode_before = data.mode_before;
  assign out_ch.changed     = data.changed;
  assign out_ch.status      = data.status;

endmodule

FILE: hdl/event_mode_controller_with_timeouts_unit.sv
// Top level of the event mode controller: input register, state machine, result register.
// Depends on emc_pkg, emc_if, emc_in_stage, emc_fsm and emc_out_stage.
//
//  channel | dir | word
//  --------+-----+------------------------------------------------------
//  in_ch   | in  | command, elapsed_ms, listening, start_safe
//  out_ch  | out | mode_now, mode_before, changed, status
//  cfg     | in  | cfg_wr_en / cfg_wr_data: idle timeout in seconds
//
// One event word per cycle sustained while out_ch is ready; an accepted word sits in the
// input register, then the state update loads its valid result word into the result register.
// The state update is one add and compare per timer (26 bits at most), combinational.
// rst is synchronous: mode boot, not started, timers zero, timeout 120 s.
// A stalled out_ch holds its word; input keeps flowing until both stages fill.
module event_mode_controller_with_timeouts_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  emc_in_if.sink      in_ch,
  emc_out_if.source   out_ch
);

  logic             s1_vld;
  emc_pkg::item_t   s1_item;
  emc_pkg::result_t res;
  logic             can_load;
  logic             adv;

  // The held event is processed when the result register has room.
  assign adv = s1_vld && can_load;

  emc_in_stage u_in (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .adv   (adv),
    .vld   (s1_vld),
    .item  (s1_item)
  );

  // State commits on the same edge that loads the result word.
  emc_fsm u_fsm (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (adv),
    .item        (s1_item),
    .res         (res)
  );

  emc_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (adv),
    .res      (res),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

FILE: test/event_mode_controller_with_timeouts_unit_tb.sv
`timescale 1ns / 100ps
// Testbench of event_mode_controller_with_timeouts_unit: random and directed event words in,
// mode reports out, each checked against an in-bench model. Depends on emc_pkg and emc_if.
module event_mode_controller_with_timeouts_unit_tb;
  import emc_pkg::*;

  // Command 15 has no meaning; it must be accepted (or ignored before init) with no effect.
  localparam logic [3:0]  CMD_SPARE    = 4'd15;
  localparam int unsigned DRAIN_CYCLES = 4;    // pipeline is two deep, leave some slack
  localparam int unsigned PHASE_WORDS  = 130;
  localparam int unsigned SHOW_LIMIT   = 40;   // cap on printed mismatches

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  emc_in_if  in_ch();
  emc_out_if out_ch();

  event_mode_controller_with_timeouts_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the controller state. Updated once per accepted event word,
  // in acceptance order, so it always runs ahead of the result channel.
  // ---------------------------------------------------------------------------
  mode_t                ctl_mode;
  logic                 ctl_started;
  logic [IDLE_MS_W-1:0] ctl_idle_ms;
  logic [TIMER_W-1:0]   ctl_touch_ms;
  logic [TIMER_W-1:0]   ctl_attn_ms;
  logic [15:0]          ctl_timeout_s;

  item_t       events_pending[$];  // words waiting to be driven
  result_t     reports_due[$];     // predicted result words, oldest first
  item_t       drv_word;
  int unsigned errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Apply one event to the shadow state and return the report it should produce.
  function automatic result_t next_mode_report(item_t ev);
    mode_t       prior;
    result_t     rep;
    logic [31:0] idle_limit;
    prior      = ctl_mode;
    rep.status = ST_OK;
    if (ev.command == CMD_INIT) begin
      if (ctl_started) begin
        rep.status = ST_REFUSED;
      end else begin
        // attentive timer is deliberately left alone by init
        ctl_idle_ms  = '0;
        ctl_touch_ms = '0;
        ctl_started  = 1'b1;
        ctl_mode     = ev.start_safe ? MODE_SAFE : MODE_BOOT;
      end
    end else if (!ctl_started) begin
      rep.status = ST_IGNORED;
    end else begin
      case (ev.command)
        CMD_TICK: begin
          // only the timer of the mode at entry runs; all others clear
          idle_limit = 32'(ctl_timeout_s) * 32'(MS_PER_S);
          if (prior == MODE_IDLE) begin
            ctl_idle_ms = ctl_idle_ms + IDLE_MS_W'(ev.elapsed_ms);
            if (32'(ctl_idle_ms) >= idle_limit) begin
              ctl_idle_ms = '0;
              ctl_mode    = MODE_SLEEP;
            end
          end else begin
            ctl_idle_ms = '0;
          end
          if (prior == MODE_TOUCH) begin
            ctl_touch_ms = ctl_touch_ms + TIMER_W'(ev.elapsed_ms);
            if (ctl_touch_ms >= TOUCH_LIMIT_MS) begin
              ctl_touch_ms = '0;
              ctl_mode     = MODE_IDLE;
            end
          end else begin
            ctl_touch_ms = '0;
          end
          if (prior == MODE_ATTN && !ev.listening) begin
            ctl_attn_ms = ctl_attn_ms + TIMER_W'(ev.elapsed_ms);
            if (ctl_attn_ms >= ATTN_LIMIT_MS) begin
              ctl_attn_ms = '0;
              ctl_mode    = MODE_IDLE;
            end
          end else begin
            ctl_attn_ms = '0;
          end
        end
        CMD_BOOT_DONE: begin
          if (prior == MODE_BOOT) ctl_mode = MODE_IDLE;
        end
        CMD_TAP: begin
          if (prior == MODE_IDLE) begin
            ctl_mode = MODE_ATTN;
          end else if (prior == MODE_ATTN || prior == MODE_RESP) begin
            ctl_touch_ms = '0;
            ctl_mode     = MODE_TOUCH;
          end else if (prior == MODE_SLEEP || prior == MODE_MED || prior == MODE_SILENT) begin
            ctl_mode = MODE_IDLE;
          end
        end
        CMD_LONG_PRESS: begin
          if (prior == MODE_IDLE || prior == MODE_ATTN || prior == MODE_SLEEP) begin
            ctl_touch_ms = '0;
            ctl_mode     = MODE_TOUCH;
          end else if (prior == MODE_MED || prior == MODE_SILENT) begin
            ctl_mode = MODE_IDLE;
          end
        end
        CMD_TOUCH_WAKE: begin
          if (prior == MODE_SLEEP) ctl_mode = MODE_IDLE;
        end
        CMD_VOICE_END: begin
          if (prior == MODE_ATTN) ctl_mode = MODE_IDLE;
        end
        CMD_AUDIO_START: begin
          if (prior == MODE_IDLE || prior == MODE_ATTN || prior == MODE_TOUCH)
            ctl_mode = MODE_RESP;
        end
        CMD_AUDIO_END: begin
          if (prior == MODE_RESP) ctl_mode = MODE_IDLE;
        end
        CMD_FAULT:      ctl_mode = MODE_ERROR;
        CMD_MED_IN: begin
          if (prior == MODE_IDLE) ctl_mode = MODE_MED;
        end
        CMD_MED_OUT: begin
          if (prior == MODE_MED) ctl_mode = MODE_IDLE;
        end
        CMD_SILENT_IN: begin
          if (prior == MODE_IDLE) ctl_mode = MODE_SILENT;
        end
        CMD_SILENT_OUT: begin
          if (prior == MODE_SILENT) ctl_mode = MODE_IDLE;
        end
        default: ;  // voice start and the spare code: accepted, no effect
      endcase
    end
    rep.mode_now    = ctl_mode;
    rep.mode_before = prior;
    rep.changed     = (ctl_mode != prior);
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: holds a word until accepted, predicts it on the accepting edge,
  // then inserts random gaps before the next one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        reports_due.push_back(next_mode_report({in_ch.command, in_ch.elapsed_ms,
                                                in_ch.listening, in_ch.start_safe}));
      if (!in_ch.valid || in_ch.ready) begin
        if (events_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_word          = events_pending.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.command    <= drv_word.command;
          in_ch.elapsed_ms <= drv_word.elapsed_ms;
          in_ch.listening  <= drv_word.listening;
          in_ch.start_safe <= drv_word.start_safe;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  function automatic void compare_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= SHOW_LIMIT)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure; every accepted result word is matched
  // against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (reports_due.size() == 0) begin
          errors++;
          if (errors <= SHOW_LIMIT)
            $display("%0t: unexpected result word, expected none, actual mode %0d/%0d st %0d",
                     $time, out_ch.mode_now, out_ch.mode_before, out_ch.status);
        end else begin
          result_t want;
          want = reports_due.pop_front();
          compare_field("mode_now", want.mode_now, out_ch.mode_now);
          compare_field("mode_before", want.mode_before, out_ch.mode_before);
          compare_field("changed", 4'(want.changed), 4'(out_ch.changed));
          compare_field("status", 4'(want.status), 4'(out_ch.status));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void push_event(logic [3:0] cmd, logic [15:0] dt, logic listen,
                                     logic safe);
    events_pending.push_back({cmd, dt, listen, safe});
  endfunction

  // Ticks lead the mix, mostly with short steps so the timers cross their limits often;
  // fault is held back because error mode is a dead end for the rest of the run.
  function automatic item_t random_event();
    item_t       ev;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 35)      ev.command = CMD_TICK;
    else if (pick < 38) ev.command = CMD_INIT;
    else if (pick < 40) ev.command = CMD_SPARE;
    else begin
      ev.command = 4'($urandom_range(2, 13));
      if (ev.command >= CMD_FAULT) ev.command = ev.command + 4'd1;
    end
    pick = $urandom_range(9);
    if (pick < 6)       ev.elapsed_ms = 16'($urandom_range(0, 2500));
    else if (pick == 6) ev.elapsed_ms = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    else                ev.elapsed_ms = 16'($urandom());
    ev.listening  = 1'($urandom_range(1));
    ev.start_safe = 1'($urandom_range(1));
    return ev;
  endfunction

  // Wait until every word is driven and every result is back, then a little more.
  task automatic drain();
    do @(negedge clk);
    while (events_pending.size() != 0 || in_ch.valid || reports_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Only called with the pipeline empty, so the model can switch at once.
  task automatic write_timeout(logic [15:0] secs);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= secs;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    ctl_timeout_s  = secs;
    @(negedge clk);
  endtask

  initial begin
    logic [15:0] timeouts [6];
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_INIT;
    in_ch.elapsed_ms = '0;
    in_ch.listening  = 1'b0;
    in_ch.start_safe = 1'b0;
    out_ch.ready     = 1'b0;
    ctl_mode      = MODE_BOOT;
    ctl_started   = 1'b0;
    ctl_idle_ms   = '0;
    ctl_touch_ms  = '0;
    ctl_attn_ms   = '0;
    ctl_timeout_s = 16'd120;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed walk on the reset timeout of 120 s.
    // Before init everything is ignored, fault included.
    push_event(CMD_TICK, 16'hFFFF, 1'b1, 1'b1);
    push_event(CMD_TAP, 16'd0, 1'b0, 1'b0);
    push_event(CMD_SPARE, 16'd0, 1'b0, 1'b0);
    push_event(CMD_FAULT, 16'd0, 1'b0, 1'b0);
    // Init once; a second init is refused even with safe start requested.
    push_event(CMD_INIT, 16'd0, 1'b0, 1'b0);
    push_event(CMD_INIT, 16'd0, 1'b0, 1'b1);
    push_event(CMD_SPARE, 16'hFFFF, 1'b1, 1'b1);
    push_event(CMD_TICK, 16'd500, 1'b0, 1'b0);
    push_event(CMD_BOOT_DONE, 16'd0, 1'b0, 1'b0);
    // Idle timer lands exactly on 120000 ms.
    push_event(CMD_TICK, 16'hFFFF, 1'b0, 1'b0);
    push_event(CMD_TICK, 16'd54465, 1'b0, 1'b0);
    // Touch timer: 1999 stays, 2000 returns to idle.
    push_event(CMD_LONG_PRESS, 16'd0, 1'b0, 1'b0);
    push_event(CMD_TICK, 16'd1999, 1'b0, 1'b0);
    push_event(CMD_TICK, 16'd1, 1'b0, 1'b0);
    // Attentive timer: listening clears it, 8000 without listening times out.
    push_event(CMD_TAP, 16'd0, 1'b0, 1'b0);
    push_event(CMD_TICK, 16'd7999, 1'b0, 1'b0);
    push_event(CMD_TICK, 16'd5, 1'b1, 1'b0);
    push_event(CMD_TICK, 16'd7999, 1'b0, 1'b0);
    push_event(CMD_TICK, 16'd1, 1'b0, 1'b0);
    // Responding and touch round trips.
    push_event(CMD_TAP, 16'd0, 1'b0, 1'b0);
    push_event(CMD_AUDIO_START, 16'd0, 1'b0, 1'b0);
    push_event(CMD_TAP, 16'd0, 1'b0, 1'b0);
    push_event(CMD_AUDIO_START, 16'd0, 1'b0, 1'b0);
    push_event(CMD_AUDIO_END, 16'd0, 1'b0, 1'b0);
    push_event(CMD_VOICE_START, 16'd0, 1'b0, 1'b0);
    // Meditation and silent entry and exit.
    push_event(CMD_MED_IN, 16'd0, 1'b0, 1'b0);
    push_event(CMD_LONG_PRESS, 16'd0, 1'b0, 1'b0);
    push_event(CMD_SILENT_IN, 16'd0, 1'b0, 1'b0);
    push_event(CMD_TAP, 16'd0, 1'b0, 1'b0);
    push_event(CMD_TOUCH_WAKE, 16'd0, 1'b0, 1'b0);
    drain();

    // Random phases, each with its own timeout; the idling patterns repeat every four phases.
    timeouts = '{16'd0, 16'd1, 16'd3, 16'hFFFF, 16'($urandom_range(0, 12)),
                 16'($urandom())};
    for (int p = 0; p < 6; p++) begin
      write_timeout(timeouts[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      repeat (PHASE_WORDS) events_pending.push_back(random_event());
      drain();
    end

    // Largest timeout: walk back to idle, then enough full ticks to reach sleep.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_timeout(16'hFFFF);
    while (ctl_mode != MODE_IDLE) begin
      case (ctl_mode)
        MODE_ATTN:   push_event(CMD_VOICE_END, 16'd0, 1'b0, 1'b0);
        MODE_RESP:   push_event(CMD_AUDIO_END, 16'd0, 1'b0, 1'b0);
        MODE_TOUCH:  push_event(CMD_TICK, 16'd2000, 1'b0, 1'b0);
        MODE_SLEEP:  push_event(CMD_TOUCH_WAKE, 16'd0, 1'b0, 1'b0);
        MODE_MED:    push_event(CMD_MED_OUT, 16'd0, 1'b0, 1'b0);
        MODE_SILENT: push_event(CMD_SILENT_OUT, 16'd0, 1'b0, 1'b0);
        default:     push_event(CMD_BOOT_DONE, 16'd0, 1'b0, 1'b0);
      endcase
      drain();
    end
    repeat (1001) push_event(CMD_TICK, 16'hFFFF, 1'b0, 1'b0);
    drain();

    // Fault last: error mode holds against everything, a second fault included.
    push_event(CMD_FAULT, 16'd0, 1'b0, 1'b0);
    push_event(CMD_TAP, 16'd0, 1'b0, 1'b0);
    push_event(CMD_TICK, 16'd3000, 1'b0, 1'b0);
    push_event(CMD_INIT, 16'd0, 1'b0, 1'b1);
    push_event(CMD_FAULT, 16'd0, 1'b0, 1'b0);
    push_event(CMD_SPARE, 16'd0, 1'b0, 1'b0);
    drain();

    if (errors == 0 && reports_due.size() == 0) begin
      $display("event_mode_controller_with_timeouts_unit_tb: done, clean");
    end else begin
      $display("event_mode_controller_with_timeouts_unit_tb: done, errors");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #5000000;
    $display("event_mode_controller_with_timeouts_unit_tb: done, errors");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/emc_pkg.sv
hdl/emc_if.sv
hdl/emc_in_stage.sv
hdl/emc_fsm.sv
hdl/emc_out_stage.sv
hdl/event_mode_controller_with_timeouts_unit.sv
test/event_mode_controller_with_timeouts_unit_tb.sv
